[rtl/vector_similarity_metrics_core_assert.svh]
// assertion macros for the similarity core checker
`ifndef VECTOR_SIMILARITY_METRICS_CORE_ASSERT_SVH
`define VECTOR_SIMILARITY_METRICS_CORE_ASSERT_SVH
`define VSM_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vsm assertion failed");
`define VSM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vsm assertion failed");
`endif

[rtl/vsm_pkg.sv]
`default_nettype none
package vsm_pkg;
  localparam int MaxLenDefault = 4096;
  localparam int ElemWidthDefault = 16;
  localparam int DotW = 44;
  localparam int SqW = 43;
  localparam int DiffW = 45;
  localparam int AccW = 64;
  localparam int DistW = 23;
  localparam int CosW = 16;
  localparam int RootW = 32;
  localparam int DenW = 64;

  typedef enum logic [2:0] {
    ST_ACC, ST_ROOT, ST_MUL, ST_DIV, ST_OUT
  } vsm_state_t;

  typedef struct packed {
    logic acc_en;
    logic root_start;
    logic mul_en;
    logic div_start;
    logic clear;
  } vsm_cmd_t;

  typedef struct packed {
    logic root_done;
    logic div_done;
  } vsm_stat_t;
endpackage
`default_nettype wire

[rtl/vsm_ctrl.sv]
`default_nettype none
module vsm_ctrl
  import vsm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  input  wire logic      in_last,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire vsm_stat_t stat,
  output vsm_cmd_t       cmd
);
  vsm_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACC;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      ST_ACC: begin
        in_ready = 1'b1;
        cmd.acc_en = in_valid;
        if (in_valid && in_last) begin
          cmd.root_start = 1'b1;
          state_next = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (stat.root_done) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        cmd.div_start = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (stat.div_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.clear = 1'b1;
          state_next = ST_ACC;
        end
      end
      default: state_next = ST_ACC;
    endcase
  end
endmodule
`default_nettype wire

[rtl/vsm_datapath.sv]
`default_nettype none
module vsm_datapath
  import vsm_pkg::*;
#(
  parameter int MAX_LEN = MaxLenDefault,
  parameter int ELEM_WIDTH = ElemWidthDefault
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic signed [ELEM_WIDTH-1:0] elem_a,
  input  wire logic signed [ELEM_WIDTH-1:0] elem_b,
  input  wire vsm_cmd_t                     cmd,
  output vsm_stat_t                         stat,
  output logic [DotW-1:0]                   dot_value,
  output logic [DistW-1:0]                  distance,
  output logic [CosW-1:0]                   cosine,
  output logic                              zero_norm,
  output logic                              length_overflow
);
  localparam int CntW = $clog2(MAX_LEN + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_LEN);

  logic [AccW-1:0] s_prod, s_sqa, s_sqb, s_diff;
  logic [CntW-1:0] cnt;
  logic            ovf;
  logic signed [ELEM_WIDTH:0]     diff;
  logic signed [2*ELEM_WIDTH-1:0] p_ab, p_aa, p_bb;
  logic signed [2*ELEM_WIDTH+1:0] p_dd;

  assign diff = {elem_a[ELEM_WIDTH-1], elem_a} - {elem_b[ELEM_WIDTH-1], elem_b};
  assign p_ab = elem_a * elem_b;
  assign p_aa = elem_a * elem_a;
  assign p_bb = elem_b * elem_b;
  assign p_dd = diff * diff;

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      s_prod <= '0;
      s_sqa <= '0;
      s_sqb <= '0;
      s_diff <= '0;
      cnt <= '0;
      ovf <= 1'b0;
    end else if (cmd.acc_en) begin
      if (cnt == CntMax) begin
        ovf <= 1'b1;
      end else begin
        s_prod <= s_prod + AccW'(p_ab);
        s_sqa <= s_sqa + AccW'(p_aa);
        s_sqb <= s_sqb + AccW'(p_bb);
        s_diff <= s_diff + AccW'(p_dd);
        cnt <= cnt + 1'b1;
      end
    end
  end

  // sums including the flagged pair, seen at the start of the roots
  logic [AccW-1:0] s_sqa_f, s_sqb_f, s_diff_f, s_prod_f;
  logic            take;
  assign take = (cnt != CntMax);
  assign s_sqa_f = take ? s_sqa + AccW'(p_aa) : s_sqa;
  assign s_sqb_f = take ? s_sqb + AccW'(p_bb) : s_sqb;
  assign s_diff_f = take ? s_diff + AccW'(p_dd) : s_diff;
  assign s_prod_f = take ? s_prod + AccW'(p_ab) : s_prod;

  // three square roots share one iteration counter, one root bit a step
  logic [AccW-1:0]  rv_a, rv_b, rv_d, rr_a, rr_b, rr_d;
  logic [5:0]       rstep;
  logic             rbusy;
  logic [AccW-1:0]  rbit;

  assign rbit = AccW'(1) << {rstep, 1'b0};

  function automatic logic [2*AccW-1:0] sq_step(input logic [AccW-1:0] v,
                                                input logic [AccW-1:0] r,
                                                input logic [AccW-1:0] b);
    logic [AccW:0] t;
    t = {1'b0, r} + {1'b0, b};
    if ({1'b0, v} >= t) begin
      sq_step = {v - t[AccW-1:0], (r >> 1) + b};
    end else begin
      sq_step = {v, r >> 1};
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      rbusy <= 1'b0;
      rstep <= '0;
    end else if (cmd.root_start) begin
      rbusy <= 1'b1;
      rstep <= 6'd31;
    end else if (rbusy) begin
      if (rstep == '0) begin
        rbusy <= 1'b0;
      end else begin
        rstep <= rstep - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.root_start) begin
      rv_a <= s_sqa_f;
      rv_b <= s_sqb_f;
      rv_d <= s_diff_f;
      rr_a <= '0;
      rr_b <= '0;
      rr_d <= '0;
    end else if (rbusy) begin
      {rv_a, rr_a} <= sq_step(rv_a, rr_a, rbit);
      {rv_b, rr_b} <= sq_step(rv_b, rr_b, rbit);
      {rv_d, rr_d} <= sq_step(rv_d, rr_d, rbit);
    end
  end

  logic [AccW-1:0] dot_hold;
  logic            ovf_hold;
  always_ff @(posedge clk) begin
    if (cmd.root_start) begin
      dot_hold <= s_prod_f;
      ovf_hold <= ovf | ~take;
    end
  end

  assign stat.root_done = rbusy && (rstep == '0);

  // denominator and restoring divide, one quotient bit a step
  logic [DenW-1:0] den;
  logic            neg;
  logic [AccW-1:0] mag, rem;
  logic [CosW-2:0] quo;
  logic [3:0]      dstep;
  logic            dbusy, sat, zn;
  logic [AccW:0]   rem_sh;

  assign rem_sh = {rem, 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      den <= rr_a[RootW-1:0] * rr_b[RootW-1:0];
    end
  end

  assign neg = dot_hold[AccW-1];
  assign mag = neg ? (~dot_hold + 1'b1) : dot_hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy <= 1'b0;
      dstep <= '0;
    end else if (cmd.div_start) begin
      dbusy <= 1'b1;
      dstep <= '0;
    end else if (dbusy) begin
      if (dstep == 4'd15) begin
        dbusy <= 1'b0;
      end else begin
        dstep <= dstep + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dbusy) begin
      if (dstep == '0) begin
        zn <= (den == '0);
        sat <= (mag >= den);
        rem <= mag;
        quo <= '0;
      end else if (rem_sh >= {1'b0, den}) begin
        rem <= rem_sh[AccW-1:0] - den;
        quo <= {quo[CosW-3:0], 1'b1};
      end else begin
        rem <= rem_sh[AccW-1:0];
        quo <= {quo[CosW-3:0], 1'b0};
      end
    end
  end

  assign stat.div_done = dbusy && (dstep == 4'd15);

  always_comb begin
    if (zn) begin
      cosine = '0;
    end else if (sat) begin
      cosine = neg ? 16'h8000 : 16'h7fff;
    end else if (neg) begin
      cosine = ~{1'b0, quo} + 1'b1;
    end else begin
      cosine = {1'b0, quo};
    end
  end

  assign dot_value = dot_hold[DotW-1:0];
  assign distance = rr_d[DistW-1:0];
  assign zero_norm = zn;
  assign length_overflow = ovf_hold;
endmodule
`default_nettype wire

[rtl/vector_similarity_metrics_core.sv]
// Vector similarity core. Element pairs are taken one per cycle on s_axis while the block is
// accumulating; the pair with tlast set closes the vectors and one result follows on m_axis:
// dot product, floor square root of the summed squared differences, and the cosine in signed
// Q1.15 (zero with zero_norm set when either norm root is zero). Pairs past MAX_LEN are left
// out and flagged. After the closing pair the block works out the three square roots (one root
// bit a cycle), then the norm product and then the bit-serial divide, and holds the result
// until it is taken; no new pair is taken in that time.
`default_nettype none
module vector_similarity_metrics_core
  import vsm_pkg::*;
#(
  parameter int MAX_LEN = MaxLenDefault,
  parameter int ELEM_WIDTH = ElemWidthDefault
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire logic [((2*ELEM_WIDTH+7)/8)*8-1:0] s_axis_tdata,  // elem_a, elem_b
  input  wire logic                    s_axis_tlast,
  output logic                         m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  output logic [87:0]                  m_axis_tdata,  // dot_value, distance, cosine
  output logic [1:0]                   m_axis_tuser   // zero_norm, length_overflow
);
  vsm_cmd_t  cmd;
  vsm_stat_t stat;
  logic [DotW-1:0]  dot_value;
  logic [DistW-1:0] distance;
  logic [CosW-1:0]  cosine;
  logic             zero_norm, length_overflow;

  vsm_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_last(s_axis_tlast), .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .stat(stat), .cmd(cmd)
  );

  vsm_datapath #(.MAX_LEN(MAX_LEN), .ELEM_WIDTH(ELEM_WIDTH)) u_dp (
    .clk(clk), .rst(rst),
    .elem_a(s_axis_tdata[ELEM_WIDTH-1:0]),
    .elem_b(s_axis_tdata[2*ELEM_WIDTH-1:ELEM_WIDTH]),
    .cmd(cmd), .stat(stat),
    .dot_value(dot_value), .distance(distance), .cosine(cosine),
    .zero_norm(zero_norm), .length_overflow(length_overflow)
  );

  assign m_axis_tdata = {5'b0, cosine, distance, dot_value};
  assign m_axis_tuser = {length_overflow, zero_norm};
endmodule
`default_nettype wire

[rtl/vsm_checker.sv]
`default_nettype none
`include "vector_similarity_metrics_core_assert.svh"
module vsm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        s_axis_tlast,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [87:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser
);
  `VSM_ASSERT_IMPL(no_take_while_result, clk, rst, m_axis_tvalid, !s_axis_tready)
  `VSM_ASSERT_NEXT(last_stops_input, clk, rst,
                   s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready)
  `VSM_ASSERT_IMPL(zero_norm_zero_cos, clk, rst, m_axis_tvalid && m_axis_tuser[0],
                   m_axis_tdata[82:67] == 16'h0)
  `VSM_ASSERT_NEXT(result_holds, clk, rst, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata))
endmodule
bind vector_similarity_metrics_core vsm_checker u_vsm_checker (
  .clk(clk), .rst(rst),
  .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .s_axis_tlast(s_axis_tlast),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);
`default_nettype wire

[verif/vector_similarity_metrics_core_test.sv]
`timescale 1ns / 1ps
module vector_similarity_metrics_core_test;
  import vsm_pkg::*;

  localparam int MaxLen = MaxLenDefault;
  localparam int Ew = ElemWidthDefault;
  localparam longint CycleLimit = 600000;

  typedef struct packed {
    logic signed [Ew-1:0] a;
    logic signed [Ew-1:0] b;
    logic last;
  } pair_t;

  typedef struct packed {
    logic [DotW-1:0] dot;
    logic [DistW-1:0] dist_val;
    logic [CosW-1:0] cos;
    logic zero_norm;
    logic len_ovf;
  } metrics_t;

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [2*Ew-1:0] s_axis_tdata = '0;
  logic s_axis_tlast = 0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [87:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;

  vector_similarity_metrics_core DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always #6 clk = ~clk;

  pair_t pending_pairs[$];
  metrics_t expected_metrics[$];
  int errors = 0;
  longint cycles = 0;
  int queued = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_off = 0;

  // running sums, kept modulo 2^64
  logic [63:0] acc_prod, acc_sq_a, acc_sq_b, acc_sq_diff;
  int acc_count;
  bit acc_ovf;

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r, bit_w;
    r = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w >>= 2;
    while (bit_w != 0) begin
      if (v >= r + bit_w) begin
        v -= r + bit_w;
        r = (r >> 1) + bit_w;
      end else begin
        r >>= 1;
      end
      bit_w >>= 2;
    end
    return r;
  endfunction

  function automatic logic [15:0] cosine_q15(logic [63:0] dot, logic [63:0] den);
    logic neg;
    logic [63:0] mag, rem, q;
    logic top;
    neg = dot[63];
    mag = neg ? -dot : dot;
    if (mag >= den) return neg ? 16'h8000 : 16'h7fff;
    rem = mag;
    q = 0;
    for (int i = 0; i < 15; i++) begin
      top = rem[63];
      rem = rem << 1;
      q = q << 1;
      if (top || rem >= den) begin
        rem -= den;
        q[0] = 1'b1;
      end
    end
    return neg ? 16'(-q) : 16'(q);
  endfunction

  task automatic accumulate_pair(pair_t p);
    longint sa, sb, d;
    logic [63:0] den;
    metrics_t m;
    sa = p.a;
    sb = p.b;
    if (acc_count >= MaxLen) begin
      acc_ovf = 1;
    end else begin
      d = sa - sb;
      acc_prod += sa * sb;
      acc_sq_a += sa * sa;
      acc_sq_b += sb * sb;
      acc_sq_diff += d * d;
      acc_count++;
    end
    if (p.last) begin
      den = int_sqrt(acc_sq_a) * int_sqrt(acc_sq_b);
      m.dot = acc_prod[DotW-1:0];
      m.dist_val = DistW'(int_sqrt(acc_sq_diff));
      m.zero_norm = (den == 0);
      m.cos = m.zero_norm ? '0 : cosine_q15(acc_prod, den);
      m.len_ovf = acc_ovf;
      expected_metrics.push_back(m);
      acc_prod = 0; acc_sq_a = 0; acc_sq_b = 0; acc_sq_diff = 0;
      acc_count = 0; acc_ovf = 0;
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [Ew-1:0] rand_elem();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(0, 20)) - 10);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_vector(int n, int mode);
    pair_t p;
    logic [Ew-1:0] x;
    for (int i = 0; i < n; i++) begin
      x = rand_elem();
      p.a = x;
      case (mode)
        0: p.b = rand_elem();
        1: p.b = x;
        2: p.b = -x;
        3: p.b = x + 16'($urandom_range(0, 6)) - 16'd3;
        default: p.b = '0;
      endcase
      p.last = (i == n - 1);
      pending_pairs.push_back(p);
      queued++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        accumulate_pair(pending_pairs.pop_front());
        send_gap <= pick_gap();
      end
      if ((s_axis_tvalid && s_axis_tready) || !s_axis_tvalid) begin
        if (pending_pairs.size() > 0 && (s_axis_tvalid ? send_gap == 0 : send_gap == 0)) begin
          s_axis_tvalid <= 1;
          {s_axis_tdata, s_axis_tlast} <= {pending_pairs[0].b, pending_pairs[0].a,
                                           pending_pairs[0].last};
        end else begin
          s_axis_tvalid <= 0;
          if (send_gap > 0) send_gap <= send_gap - 1;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    metrics_t exp_m;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_metrics.size() == 0) begin
          $error("unexpected transaction dot=%h", m_axis_tdata[DotW-1:0]);
          errors++;
        end else begin
          exp_m = expected_metrics.pop_front();
          if (m_axis_tdata[DotW-1:0] !== exp_m.dot) begin
            $error("dot_value exp %h got %h", exp_m.dot, m_axis_tdata[DotW-1:0]); errors++;
          end
          if (m_axis_tdata[DotW+:DistW] !== exp_m.dist_val) begin
            $error("distance exp %h got %h", exp_m.dist_val, m_axis_tdata[DotW+:DistW]);
            errors++;
          end
          if (m_axis_tdata[DotW+DistW+:CosW] !== exp_m.cos) begin
            $error("cosine exp %h got %h", exp_m.cos, m_axis_tdata[DotW+DistW+:CosW]);
            errors++;
          end
          if (m_axis_tuser[0] !== exp_m.zero_norm) begin
            $error("zero_norm exp %b got %b", exp_m.zero_norm, m_axis_tuser[0]); errors++;
          end
          if (m_axis_tuser[1] !== exp_m.len_ovf) begin
            $error("length_overflow exp %b got %b", exp_m.len_ovf, m_axis_tuser[1]); errors++;
          end
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        m_axis_tready <= 0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        m_axis_tready <= 0;
      end else begin
        m_axis_tready <= 1;
        recv_gap <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    pair_t p;
    acc_prod = 0; acc_sq_a = 0; acc_sq_b = 0; acc_sq_diff = 0;
    acc_count = 0; acc_ovf = 0;
    repeat (3) @(posedge clk);
    rst <= 0;
    // directed: extremes, zero norm, opposite, identical, single pairs
    p = '{16'sh8000, 16'sh8000, 1'b0}; pending_pairs.push_back(p);
    p = '{16'sh8000, 16'sh8000, 1'b1}; pending_pairs.push_back(p);
    p = '{16'sh7fff, 16'sh8000, 1'b1}; pending_pairs.push_back(p);
    p = '{16'sh0000, 16'sh1234, 1'b1}; pending_pairs.push_back(p);
    p = '{16'sh0000, 16'sh0000, 1'b1}; pending_pairs.push_back(p);
    p = '{16'sh7fff, 16'sh7fff, 1'b0}; pending_pairs.push_back(p);
    p = '{16'sh8000, 16'sh7fff, 1'b1}; pending_pairs.push_back(p);
    p = '{16'sh0003, 16'sh0004, 1'b0}; pending_pairs.push_back(p);
    p = '{16'sh0004, 16'shfffd, 1'b1}; pending_pairs.push_back(p);
    p = '{16'shffff, 16'sh0001, 1'b1}; pending_pairs.push_back(p);
    queued += 10;
    add_vector(4, 1);
    add_vector(4, 2);
    add_vector(3, 4);
    // long receiver stall while pairs keep coming
    wait (pending_pairs.size() == 0);
    hold_off <= 400;
    add_vector(2, 0);
    add_vector(3, 0);
    add_vector(2, 3);
    while (queued < 1100)
      add_vector($urandom_range(1, 12), $urandom_range(0, 4));
    wait (pending_pairs.size() == 0 && !s_axis_tvalid);
    wait (expected_metrics.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_metrics.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
